### hdl/bae_pkg.sv
// Package: shared widths, register indexes and word types of the button edge and repeat unit.
package bae_pkg;

    localparam int FIELD_W          = 32;
    localparam int PAD_W            = 16;
    localparam int ANALOG_W         = 8;
    localparam int BUTTON_BITS_DEF  = 32;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MASK   = 2'd0;
    localparam logic [1:0] REG_DELAY  = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    typedef struct packed {
        logic                pad_present;
        logic [PAD_W-1:0]    pad_buttons;
        logic [FIELD_W-1:0]  stick_dir;
        logic [ANALOG_W-1:0] analog_a_in;
        logic [ANALOG_W-1:0] analog_b_in;
        logic [ANALOG_W-1:0] trigger_left_in;
        logic [ANALOG_W-1:0] trigger_right_in;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  held;
        logic [FIELD_W-1:0]  pressed;
        logic [FIELD_W-1:0]  released;
        logic [FIELD_W-1:0]  repeat_events;
        logic [ANALOG_W-1:0] analog_a;
        logic [ANALOG_W-1:0] analog_b;
        logic [ANALOG_W-1:0] trigger_left;
        logic [ANALOG_W-1:0] trigger_right;
    } out_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] repeat_mask;
        logic [FIELD_W-1:0] repeat_delay;
        logic [FIELD_W-1:0] repeat_period;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

### hdl/bae_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module bae_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bae_pkg::FIELD_W-1:0] dividend,
    input  logic [bae_pkg::FIELD_W-1:0] divisor,
    output logic                        busy,
    output logic                        rem_zero
);
    import bae_pkg::*;

    localparam int CNT_W = $clog2(FIELD_W);

    logic [FIELD_W-1:0] rem_reg, rem_next;
    logic [FIELD_W-1:0] dvd_reg;
    logic [FIELD_W-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [FIELD_W:0]   trial;
    logic [FIELD_W:0]   diff;

    // Shift in one dividend bit and subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[FIELD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (!diff[FIELD_W])
            rem_next = diff[FIELD_W-1:0];
        else
            rem_next = trial[FIELD_W-1:0];
    end

    // Control: busy flag and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(FIELD_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    // Datapath: partial remainder and dividend shifter
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[FIELD_W-2:0], 1'b0};
        end
    end

    assign busy     = busy_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

### hdl/bae_dp.sv
// Datapath: input capture, edge and repeat evaluation, repeat state and result register.
module bae_dp #(
    parameter int BUTTON_BITS = bae_pkg::BUTTON_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bae_pkg::in_word_t  in_data,
    input  bae_pkg::cfg_t      cfg,
    input  logic               cfg_clear,
    input  bae_pkg::cmd_t      cmd,
    output bae_pkg::sts_t      sts,
    output logic               out_valid,
    input  logic               out_ready,
    output bae_pkg::out_word_t out_data
);
    import bae_pkg::*;

    // Captured word of the frame
    logic [BUTTON_BITS-1:0] word_reg;
    logic                   present_reg;
    logic [ANALOG_W-1:0]    ana_a_reg, ana_b_reg, trg_l_reg, trg_r_reg;

    // Repeat state
    logic [BUTTON_BITS-1:0] held_reg, held_next;
    logic [BUTTON_BITS-1:0] last_reg, last_next;
    logic [FIELD_W-1:0]     timer_reg, timer_next;

    // Result register
    logic      out_valid_reg;
    out_word_t out_data_reg;

    logic [BUTTON_BITS-1:0] mask_b;
    logic [BUTTON_BITS-1:0] set_w;
    logic [BUTTON_BITS-1:0] rep_m;
    logic [BUTTON_BITS-1:0] pressed_w, released_w, rep_w;
    logic [FIELD_W-1:0]     t_inc;
    logic                   active;
    logic                   same_set;
    logic                   need_div;
    logic                   div_busy;
    logic                   rem_zero;
    logic [PAD_W-1:0]       pad_w;

    assign pad_w = in_data.pad_present ? in_data.pad_buttons : '0;

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg    <= in_data.stick_dir[BUTTON_BITS-1:0] | BUTTON_BITS'(pad_w);
            present_reg <= in_data.pad_present;
            ana_a_reg   <= in_data.analog_a_in;
            ana_b_reg   <= in_data.analog_b_in;
            trg_l_reg   <= in_data.trigger_left_in;
            trg_r_reg   <= in_data.trigger_right_in;
        end
    end

    // Evaluate edges and repeat decision
    always_comb
    begin
        mask_b     = cfg.repeat_mask[BUTTON_BITS-1:0];
        active     = (cfg.repeat_delay != '0) && (cfg.repeat_mask != '0);
        set_w      = word_reg & mask_b;
        same_set   = (set_w == last_reg);
        t_inc      = timer_reg + FIELD_W'(1);
        need_div   = active && (set_w != '0) && same_set && (t_inc != cfg.repeat_delay)
                     && (t_inc > cfg.repeat_delay) && (cfg.repeat_period != '0);
        rep_m      = '0;
        last_next  = last_reg;
        timer_next = timer_reg;
        if (active)
        begin
            priority if (set_w == '0)
            begin
                last_next  = '0;
                timer_next = '0;
            end
            else if (same_set)
            begin
                timer_next = t_inc;
                if ((t_inc == cfg.repeat_delay) || (need_div && rem_zero))
                    rep_m = set_w;
            end
            else
            begin
                rep_m      = set_w & ~last_reg;
                last_next  = set_w;
                timer_next = '0;
            end
        end
        pressed_w  = word_reg & ~held_reg;
        released_w = held_reg & ~word_reg;
        rep_w      = rep_m | (~mask_b & pressed_w);
        held_next  = word_reg;
    end

    // Remainder of frames past the delay by the period
    bae_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (t_inc - cfg.repeat_delay),
        .divisor  (cfg.repeat_period),
        .busy     (div_busy),
        .rem_zero (rem_zero)
    );

    // Hold repeat state; drop the repeat set and timer on a config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            last_reg  <= '0;
            timer_reg <= '0;
        end
        else if (cfg_clear)
        begin
            last_reg  <= '0;
            timer_reg <= '0;
        end
        else if (cmd.commit)
        begin
            held_reg  <= held_next;
            last_reg  <= last_next;
            timer_reg <= timer_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg.held          <= FIELD_W'(word_reg);
            out_data_reg.pressed       <= FIELD_W'(pressed_w);
            out_data_reg.released      <= FIELD_W'(released_w);
            out_data_reg.repeat_events <= FIELD_W'(rep_w);
            out_data_reg.analog_a      <= present_reg ? ana_a_reg : '0;
            out_data_reg.analog_b      <= present_reg ? ana_b_reg : '0;
            out_data_reg.trigger_left  <= present_reg ? trg_l_reg : '0;
            out_data_reg.trigger_right <= present_reg ? trg_r_reg : '0;
        end
    end

    assign sts.need_div = need_div;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // Checks on result consistency
    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.pressed & out_data_reg.released) == '0))
        else $error("press and release set on the same button");

    a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.repeat_events & ~out_data_reg.held) == '0))
        else $error("repeat event on a button not held");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed word not presented");

    a_no_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !div_busy)
        else $error("commit while remainder unit busy");

endmodule

### hdl/bae_ctrl.sv
// Controller: sequences capture, evaluation, remainder and result commit of one word.
module bae_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bae_pkg::sts_t sts,
    output bae_pkg::cmd_t cmd
);
    import bae_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = in_valid && ready_reg;
        cmd.start  = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.need_div)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // Hold state and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

    // Sequencing checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == ST_IDLE))
        else $error("ready out of step with state");

    a_load_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EVAL))
        else $error("accepted word not evaluated");

    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_DIV) && sts.div_busy)
        else $error("remainder unit not started");

endmodule

### hdl/button_edge_and_auto_repeat_unit.sv
// Top level: APB register file, controller and datapath of the button edge and repeat unit.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+-----------------------
//  in       | input     | in_valid / in_ready        | bae_pkg::in_word_t
//  out      | output    | out_valid / out_ready      | bae_pkg::out_word_t
//  apb      | input     | psel/penable/pwrite/pready | 32-bit registers 0x0-0x8
//
// A word passes from acceptance through evaluation to the result commit, with a pass
// through the restoring remainder unit (32 steps) when a repeat past the delay needs
// the period remainder. The next word is accepted the cycle after the commit; a result
// waiting on out_ready stalls only the commit of the next one.
// Reset (rst_n, asynchronous) clears registers, held word, repeat set and timer.
// A register write clears the repeat set and timer.
module button_edge_and_auto_repeat_unit #(
    parameter int BUTTON_BITS = bae_pkg::BUTTON_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bae_pkg::in_word_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bae_pkg::out_word_t         out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bae_pkg::ADDR_W-1:0] paddr,
    input  logic [bae_pkg::DATA_W-1:0] pwdata,
    output logic [bae_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bae_pkg::*;

    logic [FIELD_W-1:0] mask_reg, delay_reg, period_reg;
    logic [1:0]         reg_idx;
    logic               wr_en;
    logic               cfg_clear;
    cfg_t               cfg;
    cmd_t               cmd;
    sts_t               sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Decode writes that hit a register
    always_comb
    begin
        unique case (reg_idx)
            REG_MASK, REG_DELAY, REG_PERIOD: cfg_clear = wr_en;
            default:                         cfg_clear = 1'b0;
        endcase
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            delay_reg  <= '0;
            period_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MASK:   mask_reg   <= pwdata;
                REG_DELAY:  delay_reg  <= pwdata;
                REG_PERIOD: period_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_MASK:   prdata = mask_reg;
            REG_DELAY:  prdata = delay_reg;
            REG_PERIOD: prdata = period_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.repeat_mask   = mask_reg;
    assign cfg.repeat_delay  = delay_reg;
    assign cfg.repeat_period = period_reg;

    bae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bae_dp #(
        .BUTTON_BITS (BUTTON_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
